[sv/kot_pkg.sv]
package kot_pkg;

    // field widths
    localparam int CH_WIDTH   = 8;
    localparam int CODE_WIDTH = 5;

    // lookahead window at the queue head: the head byte plus the bytes after it
    localparam int LOOKAHEAD_DEPTH = 4;
    localparam int WIN_DEPTH       = LOOKAHEAD_DEPTH + 1;

    // shift queue between front and back
    localparam int QUEUE_DEPTH = 8;
    localparam int Q_IDX_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    // keyword lengths and the count of bytes still to send after the first
    localparam int KW_BEGIN_LEN = 5;
    localparam int KW_END_LEN   = 3;
    localparam int KW_LEFT_W    = 3;

    // token codes
    localparam logic [CODE_WIDTH-1:0] CODE_ERROR  = 5'd0;
    localparam logic [CODE_WIDTH-1:0] CODE_BEGIN  = 5'd1;
    localparam logic [CODE_WIDTH-1:0] CODE_END    = 5'd2;
    localparam logic [CODE_WIDTH-1:0] CODE_IDENT  = 5'd10;
    localparam logic [CODE_WIDTH-1:0] CODE_NUMBER = 5'd11;
    localparam logic [CODE_WIDTH-1:0] CODE_PLUS   = 5'd13;
    localparam logic [CODE_WIDTH-1:0] CODE_MINUS  = 5'd14;
    localparam logic [CODE_WIDTH-1:0] CODE_STAR   = 5'd15;
    localparam logic [CODE_WIDTH-1:0] CODE_SLASH  = 5'd16;
    localparam logic [CODE_WIDTH-1:0] CODE_SEMI   = 5'd17;
    localparam logic [CODE_WIDTH-1:0] CODE_EQ     = 5'd18;
    localparam logic [CODE_WIDTH-1:0] CODE_LT     = 5'd19;
    localparam logic [CODE_WIDTH-1:0] CODE_NE     = 5'd20;
    localparam logic [CODE_WIDTH-1:0] CODE_LE     = 5'd21;
    localparam logic [CODE_WIDTH-1:0] CODE_GT     = 5'd22;
    localparam logic [CODE_WIDTH-1:0] CODE_GE     = 5'd23;
    localparam logic [CODE_WIDTH-1:0] CODE_LPAR   = 5'd24;
    localparam logic [CODE_WIDTH-1:0] CODE_RPAR   = 5'd25;
    localparam logic [CODE_WIDTH-1:0] CODE_HASH   = 5'd26;

    // character codes
    localparam logic [CH_WIDTH-1:0] CHAR_NL    = 8'h0A;
    localparam logic [CH_WIDTH-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CH_WIDTH-1:0] CHAR_HASH  = 8'h23;
    localparam logic [CH_WIDTH-1:0] CHAR_LPAR  = 8'h28;
    localparam logic [CH_WIDTH-1:0] CHAR_RPAR  = 8'h29;
    localparam logic [CH_WIDTH-1:0] CHAR_STAR  = 8'h2A;
    localparam logic [CH_WIDTH-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CH_WIDTH-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CH_WIDTH-1:0] CHAR_SLASH = 8'h2F;
    localparam logic [CH_WIDTH-1:0] CHAR_SEMI  = 8'h3B;
    localparam logic [CH_WIDTH-1:0] CHAR_LT    = 8'h3C;
    localparam logic [CH_WIDTH-1:0] CHAR_EQ    = 8'h3D;
    localparam logic [CH_WIDTH-1:0] CHAR_GT    = 8'h3E;
    localparam logic [CH_WIDTH-1:0] CHAR_B     = 8'h62;
    localparam logic [CH_WIDTH-1:0] CHAR_D     = 8'h64;
    localparam logic [CH_WIDTH-1:0] CHAR_E     = 8'h65;
    localparam logic [CH_WIDTH-1:0] CHAR_G     = 8'h67;
    localparam logic [CH_WIDTH-1:0] CHAR_I     = 8'h69;
    localparam logic [CH_WIDTH-1:0] CHAR_N     = 8'h6E;

    // one classified byte as it waits in the queue
    typedef struct packed {
        logic [CH_WIDTH-1:0]   ch;
        logic                  eol;
        logic                  is_digit;
        logic                  is_letter;
        logic                  is_skip;
        logic [CODE_WIDTH-1:0] op_code;
    } char_entry_t;

    // queue status seen by front and back
    typedef struct packed {
        logic [Q_CNT_W-1:0] count;
        logic               full;
    } q_stat_t;

endpackage

[sv/kot_front.sv]
module kot_front import kot_pkg::*; (
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [CH_WIDTH-1:0] s_tdata,
    input  logic                s_tlast,
    input  q_stat_t             q_stat,
    output logic                push,
    output char_entry_t         push_entry
);

    // one-character operator code, error code for anything else
    function automatic logic [CODE_WIDTH-1:0] single_op(input logic [CH_WIDTH-1:0] c);
        logic [CODE_WIDTH-1:0] code;
        unique case (c)
            CHAR_PLUS:  code = CODE_PLUS;
            CHAR_MINUS: code = CODE_MINUS;
            CHAR_STAR:  code = CODE_STAR;
            CHAR_SLASH: code = CODE_SLASH;
            CHAR_SEMI:  code = CODE_SEMI;
            CHAR_EQ:    code = CODE_EQ;
            CHAR_LT:    code = CODE_LT;
            CHAR_GT:    code = CODE_GT;
            CHAR_LPAR:  code = CODE_LPAR;
            CHAR_RPAR:  code = CODE_RPAR;
            CHAR_HASH:  code = CODE_HASH;
            default:    code = CODE_ERROR;
        endcase
        return code;
    endfunction

    // accept a request whenever the queue has room
    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && s_tready;

    // classify the byte on the way in
    always_comb begin
        push_entry.ch        = s_tdata;
        push_entry.eol       = s_tlast;
        push_entry.is_digit  = (s_tdata >= 8'h30) && (s_tdata <= 8'h39);
        push_entry.is_letter = ((s_tdata >= 8'h61) && (s_tdata <= 8'h7A))
                            || ((s_tdata >= 8'h41) && (s_tdata <= 8'h5A));
        push_entry.is_skip   = (s_tdata == CHAR_SPACE) || (s_tdata == CHAR_NL);
        push_entry.op_code   = single_op(s_tdata);
    end

endmodule

[sv/kot_queue.sv]
module kot_queue import kot_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push,
    input  char_entry_t                   push_entry,
    input  logic                          pop,
    output q_stat_t                       q_stat,
    output char_entry_t [WIN_DEPTH-1:0]   win
);

    char_entry_t          entries_reg  [QUEUE_DEPTH];
    char_entry_t          entries_next [QUEUE_DEPTH];
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;
    logic [Q_CNT_W-1:0]   count_after_pop;

    // shift down on pop, write behind the last kept entry on push
    always_comb begin
        count_after_pop = count_reg - Q_CNT_W'(pop);
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            entries_next[i] = entries_reg[i];
        end
        if (pop) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                entries_next[i] = entries_reg[i + 1];
            end
        end
        if (push) begin
            entries_next[count_after_pop[Q_IDX_W-1:0]] = push_entry;
        end
        count_next = count_after_pop + Q_CNT_W'(push);
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            entries_reg[i] <= entries_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // fixed taps at the head
    always_comb begin
        for (int i = 0; i < WIN_DEPTH; i++) begin
            win[i] = entries_reg[i];
        end
    end

    assign q_stat.count = count_reg;
    assign q_stat.full  = (count_reg == Q_CNT_W'(QUEUE_DEPTH));

    // occupancy never passes the depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= Q_CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

endmodule

[sv/kot_back.sv]
module kot_back import kot_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  q_stat_t                       q_stat,
    input  char_entry_t [WIN_DEPTH-1:0]   win,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [CH_WIDTH-1:0]           m_tdata,
    output logic [CODE_WIDTH-1:0]         m_tuser,
    output logic                          m_tlast
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_NUM   = 4'b0010,
        ST_IDENT = 4'b0100,
        ST_FIXED = 4'b1000
    } scan_state_t;

    scan_state_t           state_reg, state_next;
    logic [KW_LEFT_W-1:0]  left_reg, left_next;
    logic [CODE_WIDTH-1:0] code_reg, code_next;
    logic                  valid_reg, valid_next;
    logic [CH_WIDTH-1:0]   char_reg;
    logic [CODE_WIDTH-1:0] tok_reg;
    logic                  last_reg;

    char_entry_t           head, nxt;
    logic                  head_ok, next_ok, out_free;
    logic [3:0]            eol_at;
    logic                  is_b, is_e, kw_ready, kw_match, b_match, e_match;
    logic [CODE_WIDTH-1:0] dbl_code;
    logic                  num_last, id_last;
    logic                  ready, emit, e_last, fire;
    logic [CODE_WIDTH-1:0] e_code;

    assign head = win[0];
    assign nxt  = win[1];

    // what the window can already tell
    always_comb begin
        head_ok = (q_stat.count != '0);
        next_ok = head.eol || (q_stat.count >= Q_CNT_W'(2));
        for (int i = 0; i < 4; i++) begin
            eol_at[i] = (q_stat.count > Q_CNT_W'(i)) && win[i].eol;
        end
        is_b    = (head.ch == CHAR_B);
        is_e    = (head.ch == CHAR_E);
        b_match = (q_stat.count >= Q_CNT_W'(KW_BEGIN_LEN)) && (eol_at == 4'b0000)
               && (win[1].ch == CHAR_E) && (win[2].ch == CHAR_G)
               && (win[3].ch == CHAR_I) && (win[4].ch == CHAR_N);
        e_match = (q_stat.count >= Q_CNT_W'(KW_END_LEN)) && (eol_at[1:0] == 2'b00)
               && (win[1].ch == CHAR_N) && (win[2].ch == CHAR_D);
        kw_ready = is_b ? ((q_stat.count >= Q_CNT_W'(KW_BEGIN_LEN)) || (eol_at != 4'b0000))
                        : ((q_stat.count >= Q_CNT_W'(KW_END_LEN)) || (eol_at[1:0] != 2'b00));
        kw_match = is_b ? b_match : e_match;
        dbl_code = CODE_ERROR;
        if (!head.eol) begin
            priority if (head.ch == CHAR_LT && nxt.ch == CHAR_GT) begin
                dbl_code = CODE_NE;
            end else if (head.ch == CHAR_LT && nxt.ch == CHAR_EQ) begin
                dbl_code = CODE_LE;
            end else if (head.ch == CHAR_GT && nxt.ch == CHAR_EQ) begin
                dbl_code = CODE_GE;
            end else begin
                dbl_code = CODE_ERROR;
            end
        end
        num_last = head.eol || !nxt.is_digit;
        id_last  = head.eol || !(nxt.is_digit || nxt.is_letter);
    end

    // decide what the head byte does
    always_comb begin
        ready      = 1'b0;
        emit       = 1'b0;
        e_code     = CODE_ERROR;
        e_last     = 1'b1;
        state_next = state_reg;
        left_next  = left_reg;
        code_next  = code_reg;
        unique case (state_reg)
            ST_FIXED: begin
                ready     = 1'b1;
                emit      = 1'b1;
                e_code    = code_reg;
                e_last    = (left_reg == KW_LEFT_W'(1));
                left_next = left_reg - KW_LEFT_W'(1);
                if (e_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_NUM: begin
                ready  = next_ok;
                emit   = 1'b1;
                e_code = CODE_NUMBER;
                e_last = num_last;
                if (num_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDENT: begin
                ready  = next_ok;
                emit   = 1'b1;
                e_code = CODE_IDENT;
                e_last = id_last;
                if (id_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                priority if (head.is_skip) begin
                    ready = 1'b1;
                end else if (is_b || is_e) begin
                    ready = kw_ready;
                    emit  = 1'b1;
                    if (kw_match) begin
                        e_code     = is_b ? CODE_BEGIN : CODE_END;
                        e_last     = 1'b0;
                        code_next  = e_code;
                        left_next  = is_b ? KW_LEFT_W'(KW_BEGIN_LEN - 1)
                                          : KW_LEFT_W'(KW_END_LEN - 1);
                        state_next = ST_FIXED;
                    end else begin
                        e_code     = CODE_IDENT;
                        e_last     = id_last;
                        state_next = id_last ? ST_IDLE : ST_IDENT;
                    end
                end else if (head.ch == CHAR_LT || head.ch == CHAR_GT) begin
                    ready = next_ok;
                    emit  = 1'b1;
                    if (dbl_code != CODE_ERROR) begin
                        e_code     = dbl_code;
                        e_last     = 1'b0;
                        code_next  = dbl_code;
                        left_next  = KW_LEFT_W'(1);
                        state_next = ST_FIXED;
                    end else begin
                        e_code = head.op_code;
                    end
                end else if (head.is_digit) begin
                    ready      = next_ok;
                    emit       = 1'b1;
                    e_code     = CODE_NUMBER;
                    e_last     = num_last;
                    state_next = num_last ? ST_IDLE : ST_NUM;
                end else if (head.is_letter) begin
                    ready      = next_ok;
                    emit       = 1'b1;
                    e_code     = CODE_IDENT;
                    e_last     = id_last;
                    state_next = id_last ? ST_IDLE : ST_IDENT;
                end else begin
                    // single operator, or error for anything unknown
                    ready  = 1'b1;
                    emit   = 1'b1;
                    e_code = head.op_code;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // consume the head byte when decided and, if it emits, when the output register can take it
    assign out_free = !valid_reg || m_tready;
    assign fire     = head_ok && ready && (!emit || out_free);
    assign pop      = fire;

    always_comb begin
        valid_next = valid_reg;
        if (fire && emit) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (fire) begin
                state_reg <= state_next;
            end
        end
    end

    // payload of the scan and of the output register
    always_ff @(posedge aclk) begin
        if (fire) begin
            left_reg <= left_next;
            code_reg <= code_next;
        end
        if (fire && emit) begin
            char_reg <= head.ch;
            tok_reg  <= e_code;
            last_reg <= e_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = char_reg;
    assign m_tuser  = tok_reg;
    assign m_tlast  = last_reg;

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (q_stat.count != '0))
        else $error("pop from empty queue");

    a_eol_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && head.eol) |=> (state_reg == ST_IDLE))
        else $error("scan state carried past a line end");

    a_fixed_left: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIXED) |-> (left_reg != '0))
        else $error("fixed token with nothing left to send");

endmodule

[sv/keyword_operator_tokenizer_core.sv]
// result: a byte's result is registered when it is popped from the queue head, once
// its lookahead is in and the output register can take it: up to 4 later bytes for "b" at
// token start, 2 for "e", 1 for runs, "<" and ">", or fewer when a line end comes first
// throughput: one byte per cycle, set by the one-byte-a-cycle scan at the head of the 8-entry
// queue, unless lookahead or an output stall holds it; the output register holds one result
// reset: aresetn low at a clock edge empties the queue, idles the scan, drops m_tvalid
module keyword_operator_tokenizer_core import kot_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [CH_WIDTH-1:0]   s_tdata,   // [7:0] ch
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [CH_WIDTH-1:0]   m_tdata,   // [7:0] text_char
    output logic [CODE_WIDTH-1:0] m_tuser,   // [4:0] token_code
    output logic                  m_tlast
);

    q_stat_t                     q_stat;
    logic                        push;
    logic                        pop;
    char_entry_t                 push_entry;
    char_entry_t [WIN_DEPTH-1:0] win;

    kot_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .q_stat     (q_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    kot_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .q_stat     (q_stat),
        .win        (win)
    );

    kot_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .win      (win),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
